FILE: design/pfc_pkg.sv
// Shared types, format codes and constants for the pixel format converter.
package pfc_pkg;

    typedef enum logic [1:0] {
        FMT_RGB888 = 2'd0,
        FMT_BGR888 = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_GRAY   = 2'd3
    } fmt_t;

    typedef enum logic {
        REG_SOURCE_FORMAT = 1'b0,
        REG_TARGET_FORMAT = 1'b1
    } reg_index_t;

    localparam int unsigned CFG_DATA_W = 2;

    // Division by three as a multiply by ceil(2^11 / 3) and a right shift.
    // The result is exact for every sum of three bytes.
    localparam int unsigned DIV3_MUL   = 683;
    localparam int unsigned DIV3_SHIFT = 11;

    typedef logic [1:0] byte_count_t;

    typedef struct packed {
        fmt_t source_format;
        fmt_t target_format;
    } fmt_cfg_t;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
        logic       last;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0]  byte_first;
        logic [7:0]  byte_second;
        logic [7:0]  byte_third;
        byte_count_t byte_count;
        logic        unsupported;
        logic        last;
    } pixel_out_t;

    function automatic byte_count_t byte_count(input fmt_t fmt);
        byte_count_t cnt;
        unique case (fmt)
            FMT_GRAY:   cnt = 2'd1;
            FMT_RGB565: cnt = 2'd2;
            default:    cnt = 2'd3;
        endcase
        return cnt;
    endfunction

endpackage

FILE: design/pfc_convert.sv
// Combinational conversion of one registered pixel between the supported formats.
module pfc_convert (
    input  pfc_pkg::fmt_cfg_t   cfg,
    input  pfc_pkg::pixel_in_t  pix_in,
    output pfc_pkg::pixel_out_t pix_out
);

    logic [9:0]  sum3;
    logic [8:0]  sum2;
    logic [19:0] div3_prod;
    logic [7:0]  gray_rgb;
    logic [7:0]  gray_565;
    logic [15:0] word_in;
    logic [15:0] word_out;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;

    assign sum3 = {2'b00, pix_in.byte_first} + {2'b00, pix_in.byte_second}
                + {2'b00, pix_in.byte_third};
    assign sum2 = {1'b0, pix_in.byte_first} + {1'b0, pix_in.byte_second};
    assign div3_prod = {10'd0, sum3} * 20'(pfc_pkg::DIV3_MUL);
    assign gray_rgb = div3_prod[pfc_pkg::DIV3_SHIFT +: 8];
    assign gray_565 = sum2[8:1];

    // Packed 5/6/5 words travel low byte first.
    assign word_in  = {pix_in.byte_second, pix_in.byte_first};
    assign word_out = {pix_in.byte_first[7:3], pix_in.byte_second[7:2],
                       pix_in.byte_third[7:3]};

    always_comb begin
        unique case (cfg.source_format)
            pfc_pkg::FMT_RGB565: begin
                r = {word_in[15:11], 3'b000};
                g = {word_in[10:5], 2'b00};
                b = {word_in[4:0], 3'b000};
            end
            pfc_pkg::FMT_GRAY: begin
                r = pix_in.byte_first;
                g = pix_in.byte_first;
                b = pix_in.byte_first;
            end
            default: begin
                r = pix_in.byte_first;
                g = pix_in.byte_second;
                b = pix_in.byte_third;
            end
        endcase
    end

    always_comb begin
        pix_out.byte_first  = 8'd0;
        pix_out.byte_second = 8'd0;
        pix_out.byte_third  = 8'd0;
        pix_out.byte_count  = pfc_pkg::byte_count(cfg.target_format);
        pix_out.unsupported = 1'b0;
        pix_out.last        = pix_in.last;
        priority if (cfg.source_format == cfg.target_format) begin
            pix_out.byte_first = pix_in.byte_first;
            if (pix_out.byte_count >= 2'd2) begin
                pix_out.byte_second = pix_in.byte_second;
            end
            if (pix_out.byte_count == 2'd3) begin
                pix_out.byte_third = pix_in.byte_third;
            end
        end else if (cfg.source_format == pfc_pkg::FMT_BGR888) begin
            pix_out.unsupported = 1'b1;
        end else if (cfg.target_format == pfc_pkg::FMT_GRAY) begin
            if (cfg.source_format == pfc_pkg::FMT_RGB888) begin
                pix_out.byte_first = gray_rgb;
            end else begin
                pix_out.byte_first = gray_565;
            end
        end else if (cfg.target_format == pfc_pkg::FMT_RGB565) begin
            if (cfg.source_format == pfc_pkg::FMT_GRAY) begin
                pix_out.byte_first  = pix_in.byte_first;
                pix_out.byte_second = pix_in.byte_first;
            end else begin
                pix_out.byte_first  = word_out[7:0];
                pix_out.byte_second = word_out[15:8];
            end
        end else if (cfg.target_format == pfc_pkg::FMT_RGB888) begin
            pix_out.byte_first  = r;
            pix_out.byte_second = g;
            pix_out.byte_third  = b;
        end else begin
            pix_out.byte_first  = b;
            pix_out.byte_second = g;
            pix_out.byte_third  = r;
        end
    end

endmodule

FILE: design/pixel_format_converter.sv
// Top level of the pixel format converter: registers, handshakes and config.
//
//  Channel  Direction  Handshake           Carries
//  s_       in         s_valid / s_ready   one pixel request: three bytes and last
//  m_       out        m_valid / m_ready   one converted pixel, byte count, flags
//  cfg_     in         cfg_we              source and target format registers
//
// A request passes from acceptance through the input register and then the result
// register, with the conversion between them.
// One request is accepted every cycle while results are taken.
// A stall on m_ready backs up into the input register and then into s_ready.
// Reset clears both stages and sets both formats to rgb888.
module pixel_format_converter (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_in_byte_first,
    input  logic [7:0]                       s_in_byte_second,
    input  logic [7:0]                       s_in_byte_third,
    input  logic                             s_in_last,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte_first,
    output logic [7:0]                       m_out_byte_second,
    output logic [7:0]                       m_out_byte_third,
    output logic [1:0]                       m_out_byte_count,
    output logic                             m_unsupported,
    output logic                             m_out_last
);

    pfc_pkg::fmt_cfg_t   cfg_reg;
    pfc_pkg::pixel_in_t  pix_in_reg;
    logic                in_valid_reg;
    pfc_pkg::pixel_out_t pix_conv;
    pfc_pkg::pixel_out_t pix_out_reg;
    logic                out_valid_reg;
    logic                out_adv;

    assign out_adv = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_format <= pfc_pkg::FMT_RGB888;
            cfg_reg.target_format <= pfc_pkg::FMT_RGB888;
        end else if (cfg_we) begin
            unique case (pfc_pkg::reg_index_t'(cfg_index))
                pfc_pkg::REG_SOURCE_FORMAT:
                    cfg_reg.source_format <= pfc_pkg::fmt_t'(cfg_wdata);
                pfc_pkg::REG_TARGET_FORMAT:
                    cfg_reg.target_format <= pfc_pkg::fmt_t'(cfg_wdata);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pix_in_reg.byte_first  <= s_in_byte_first;
            pix_in_reg.byte_second <= s_in_byte_second;
            pix_in_reg.byte_third  <= s_in_byte_third;
            pix_in_reg.last        <= s_in_last;
        end
    end

    pfc_convert u_convert (
        .cfg     (cfg_reg),
        .pix_in  (pix_in_reg),
        .pix_out (pix_conv)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            pix_out_reg <= pix_conv;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_out_byte_first  = pix_out_reg.byte_first;
    assign m_out_byte_second = pix_out_reg.byte_second;
    assign m_out_byte_third  = pix_out_reg.byte_third;
    assign m_out_byte_count  = pix_out_reg.byte_count;
    assign m_unsupported     = pix_out_reg.unsupported;
    assign m_out_last        = pix_out_reg.last;

    // Both stages are empty in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !in_valid_reg && !out_valid_reg)
        else $error("pipeline not empty after reset");

    // An unsupported conversion carries no pixel bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_unsupported |->
            m_out_byte_first == 8'd0 && m_out_byte_second == 8'd0 &&
            m_out_byte_third == 8'd0)
        else $error("unsupported result has nonzero bytes");

    // A gray result uses only its first byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_byte_count == 2'd1 |->
            m_out_byte_second == 8'd0 && m_out_byte_third == 8'd0)
        else $error("gray result has extra bytes");

    // A valid result always names one to three bytes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_byte_count != 2'd0)
        else $error("result byte count is zero");

    // The input stage is never refilled while a full result stage is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted while both stages are stalled");

endmodule
